### design/tfdd_pkg.sv
`timescale 1ns / 1ps

package tfdd_pkg;

  localparam int TILE_SIZE_DEF  = 64;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_RESET  = 1024;
  localparam int PIX_W      = 32;
  localparam int CMD_W      = 1;

  localparam int COL_OUT_W  = 4;
  localparam int POS_OUT_W  = 10;
  localparam int SPAN_OUT_W = 7;

  localparam int OUT_DMG_BIT  = 2 * COL_OUT_W + 2 * POS_OUT_W + 2 * SPAN_OUT_W;
  localparam int OUT_FDMG_BIT = OUT_DMG_BIT + 1;
  localparam int OUT_TDATA_W  = ((OUT_FDMG_BIT + 1 + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FDMG_BIT - 1;

  localparam int OUTQ_DEPTH = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL      = 1'b0,
    CMD_INVALIDATE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic inval;
    logic complete;
    logic last;
  } step_ctl_t;

  typedef struct packed {
    logic                  last;
    logic                  frame_damaged;
    logic                  damaged;
    logic [SPAN_OUT_W-1:0] span_y;
    logic [SPAN_OUT_W-1:0] span_x;
    logic [POS_OUT_W-1:0]  top;
    logic [POS_OUT_W-1:0]  left;
    logic [COL_OUT_W-1:0]  row;
    logic [COL_OUT_W-1:0]  col;
  } tile_res_t;

endpackage

### design/tfdd_ram.sv
`timescale 1ns / 1ps

module tfdd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### design/tfdd_raster.sv
`timescale 1ns / 1ps

module tfdd_raster import tfdd_pkg::*; #(
  parameter int TILE_SIZE  = TILE_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int X_W    = $clog2(MAX_WIDTH),
  localparam int Y_W    = $clog2(MAX_HEIGHT),
  localparam int WS_W   = $clog2(MAX_WIDTH + 1),
  localparam int HS_W   = $clog2(MAX_HEIGHT + 1),
  localparam int T_W    = $clog2(TILE_SIZE),
  localparam int BAND_X = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE,
  localparam int BAND_Y = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE,
  localparam int COL_W  = (BAND_X > 1) ? $clog2(BAND_X) : 1,
  localparam int ROW_W  = (BAND_Y > 1) ? $clog2(BAND_Y) : 1,
  localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_val,
  input  logic                 step,
  input  logic                 step_inval,
  output logic [WS_W-1:0]      w_eff,
  output logic [HS_W-1:0]      h_eff,
  output logic [AW-1:0]        rd_addr,
  output logic [COL_W-1:0]     col,
  output logic [ROW_W-1:0]     row,
  output step_ctl_t            ctl
);

  localparam int W_RST = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
  localparam int H_RST = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

  function automatic logic [WS_W-1:0] clamp_w(logic [CFG_W-1:0] v);
    if (v == '0) return WS_W'(1);
    if (32'(v) > 32'(MAX_WIDTH)) return WS_W'(MAX_WIDTH);
    return WS_W'(v);
  endfunction

  function automatic logic [HS_W-1:0] clamp_h(logic [CFG_W-1:0] v);
    if (v == '0) return HS_W'(1);
    if (32'(v) > 32'(MAX_HEIGHT)) return HS_W'(MAX_HEIGHT);
    return HS_W'(v);
  endfunction

  logic [WS_W-1:0]  w_r, w_nxt;
  logic [HS_W-1:0]  h_r, h_nxt;
  logic [X_W-1:0]   x_r, x_nxt;
  logic [Y_W-1:0]   y_r, y_nxt;
  logic [T_W-1:0]   tx_r, tx_nxt;
  logic [T_W-1:0]   ty_r, ty_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]    ybase_r, ybase_nxt;
  logic             x_end, y_end, tx_end, ty_end;

  assign x_end  = (WS_W'(x_r) + WS_W'(1)) == w_r;
  assign y_end  = (HS_W'(y_r) + HS_W'(1)) == h_r;
  assign tx_end = tx_r == T_W'(TILE_SIZE - 1);
  assign ty_end = ty_r == T_W'(TILE_SIZE - 1);

  always_comb begin
    w_nxt     = w_r;
    h_nxt     = h_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ybase_nxt = ybase_r;
    if (cfg_we) begin
      if (cfg_idx == REG_WIDTH) begin
        w_nxt = clamp_w(cfg_val);
      end else begin
        h_nxt = clamp_h(cfg_val);
      end
      x_nxt     = '0;
      y_nxt     = '0;
      tx_nxt    = '0;
      ty_nxt    = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      ybase_nxt = '0;
    end else if (step) begin
      if (step_inval) begin
        x_nxt     = '0;
        y_nxt     = '0;
        tx_nxt    = '0;
        ty_nxt    = '0;
        col_nxt   = '0;
        row_nxt   = '0;
        ybase_nxt = '0;
      end else if (!x_end) begin
        x_nxt = x_r + 1'b1;
        if (tx_end) begin
          tx_nxt  = '0;
          col_nxt = col_r + 1'b1;
        end else begin
          tx_nxt = tx_r + 1'b1;
        end
      end else begin
        x_nxt   = '0;
        tx_nxt  = '0;
        col_nxt = '0;
        if (!y_end) begin
          y_nxt     = y_r + 1'b1;
          ybase_nxt = ybase_r + AW'(MAX_WIDTH);
          if (ty_end) begin
            ty_nxt  = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            ty_nxt = ty_r + 1'b1;
          end
        end else begin
          y_nxt     = '0;
          ty_nxt    = '0;
          row_nxt   = '0;
          ybase_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= WS_W'(W_RST);
      h_r     <= HS_W'(H_RST);
      x_r     <= '0;
      y_r     <= '0;
      tx_r    <= '0;
      ty_r    <= '0;
      col_r   <= '0;
      row_r   <= '0;
      ybase_r <= '0;
    end else begin
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      tx_r    <= tx_nxt;
      ty_r    <= ty_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ybase_r <= ybase_nxt;
    end
  end

  assign w_eff        = w_r;
  assign h_eff        = h_r;
  assign rd_addr      = ybase_r + AW'(x_r);
  assign col          = col_r;
  assign row          = row_r;
  assign ctl.valid    = step;
  assign ctl.inval    = step_inval;
  assign ctl.complete = (tx_end | x_end) & (ty_end | y_end);
  assign ctl.last     = x_end & y_end;

endmodule

### design/tfdd_tile.sv
`timescale 1ns / 1ps

module tfdd_tile import tfdd_pkg::*; #(
  parameter int TILE_SIZE  = TILE_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int X_W    = $clog2(MAX_WIDTH),
  localparam int Y_W    = $clog2(MAX_HEIGHT),
  localparam int WS_W   = $clog2(MAX_WIDTH + 1),
  localparam int HS_W   = $clog2(MAX_HEIGHT + 1),
  localparam int SP_W   = $clog2(TILE_SIZE + 1),
  localparam int BAND_X = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE,
  localparam int BAND_Y = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE,
  localparam int COL_W  = (BAND_X > 1) ? $clog2(BAND_X) : 1,
  localparam int ROW_W  = (BAND_Y > 1) ? $clog2(BAND_Y) : 1,
  localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  step_ctl_t        s0_ctl,
  input  logic [COL_W-1:0] s0_col,
  input  logic [ROW_W-1:0] s0_row,
  input  logic [AW-1:0]    s0_addr,
  input  logic [PIX_W-1:0] s0_pix,
  input  logic [WS_W-1:0]  w_eff,
  input  logic [HS_W-1:0]  h_eff,
  input  logic [PIX_W-1:0] ram_rdata,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [PIX_W-1:0] ram_wdata,
  output logic             res_push,
  output tile_res_t        res,
  output logic             busy
);

  step_ctl_t         s1_ctl_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [AW-1:0]     s1_addr_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              fwd_v_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [PIX_W-1:0]  fwd_data_r;
  logic [BAND_X-1:0] dirty_r, dirty_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic              any_r, any_nxt;

  logic [PIX_W-1:0]  prev_pix;
  logic              differ, dirty_col, dmg;
  logic [X_W-1:0]    left;
  logic [Y_W-1:0]    top;
  logic [WS_W-1:0]   rem_x;
  logic [HS_W-1:0]   rem_y;
  logic [SP_W-1:0]   span_x, span_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      fwd_v_r  <= 1'b0;
    end else begin
      s1_ctl_r <= s0_ctl;
      fwd_v_r  <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r   <= s0_col;
    s1_row_r   <= s0_row;
    s1_addr_r  <= s0_addr;
    s1_pix_r   <= s0_pix;
    fwd_addr_r <= ram_waddr;
    fwd_data_r <= ram_wdata;
  end

  always_comb begin
    prev_pix  = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;
    differ    = prev_pix != s1_pix_r;
    dirty_col = dirty_r[s1_col_r] | differ;
    dmg       = !have_prev_r | dirty_col;

    dirty_nxt     = dirty_r;
    have_prev_nxt = have_prev_r;
    any_nxt       = any_r;
    if (restart) begin
      dirty_nxt     = '0;
      have_prev_nxt = 1'b0;
      any_nxt       = 1'b0;
    end else if (s1_ctl_r.valid) begin
      if (s1_ctl_r.inval) begin
        dirty_nxt     = '0;
        have_prev_nxt = 1'b0;
        any_nxt       = 1'b0;
      end else begin
        dirty_nxt[s1_col_r] = dirty_col & !s1_ctl_r.complete;
        if (s1_ctl_r.complete) begin
          any_nxt = any_r | dmg;
          if (s1_ctl_r.last) begin
            have_prev_nxt = 1'b1;
            any_nxt       = 1'b0;
            dirty_nxt     = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r     <= '0;
      have_prev_r <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      dirty_r     <= dirty_nxt;
      have_prev_r <= have_prev_nxt;
      any_r       <= any_nxt;
    end
  end

  always_comb begin
    left   = X_W'(int'(s1_col_r) * TILE_SIZE);
    top    = Y_W'(int'(s1_row_r) * TILE_SIZE);
    rem_x  = w_eff - WS_W'(left);
    rem_y  = h_eff - HS_W'(top);
    span_x = (32'(rem_x) < 32'(TILE_SIZE)) ? SP_W'(rem_x) : SP_W'(TILE_SIZE);
    span_y = (32'(rem_y) < 32'(TILE_SIZE)) ? SP_W'(rem_y) : SP_W'(TILE_SIZE);
  end

  assign ram_we    = s1_ctl_r.valid & !s1_ctl_r.inval;
  assign ram_waddr = s1_addr_r;
  assign ram_wdata = s1_pix_r;
  assign res_push  = ram_we & s1_ctl_r.complete;
  assign busy      = s1_ctl_r.valid;

  assign res.col           = COL_OUT_W'(s1_col_r);
  assign res.row           = COL_OUT_W'(s1_row_r);
  assign res.left          = POS_OUT_W'(left);
  assign res.top           = POS_OUT_W'(top);
  assign res.span_x        = SPAN_OUT_W'(span_x);
  assign res.span_y        = SPAN_OUT_W'(span_y);
  assign res.damaged       = dmg;
  assign res.frame_damaged = s1_ctl_r.last & (any_r | dmg);
  assign res.last          = s1_ctl_r.last;

endmodule

### design/tfdd_outq.sv
`timescale 1ns / 1ps

module tfdd_outq import tfdd_pkg::*; #(
  parameter int DEPTH = OUTQ_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tile_res_t        push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tile_res_t        out_data,
  output logic [CNT_W-1:0] count
);

  tile_res_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign pop = out_valid & out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

### design/tile_frame_damage_detector.sv
`timescale 1ns / 1ps

// Per-tile damage detector over a raster pixel stream.
// in_*  : one beat per pixel, tuser = cmd (pixel or invalidate), tdata = pixel.
// out_* : one beat per completed tile; tlast marks the frame's final tile.
// cfg_* : surface width (index 0) and height (index 1); a write restarts
//         the frame position and reports the next frame fully damaged.
// Throughput: one pixel per cycle while in_tready is high. Each pixel
// reads the frame store in the accept cycle and writes it back in the
// next cycle; back-to-back hits on the same entry (tiny frames) are
// served from a one-entry forward register.
// Back-pressure: results drain through a three-entry queue; in_tready drops
// while the queue plus the item in flight could fill it, so nothing is lost
// while the receiver stalls.
// Reset: position, dirty bits and flags clear at once; the frame store is
// not cleared, and the first frame after reset reports every tile damaged.
module tile_frame_damage_detector import tfdd_pkg::*; #(
  parameter int TILE_SIZE  = TILE_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,   // [31:0] pixel_value
  input  logic [CMD_W-1:0]       in_tuser,   // [0] cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] tile_col, [7:4] tile_row, [17:8] tile_left, [27:18] tile_top,
  // [34:28] tile_span_x, [41:35] tile_span_y, [42] tile_changed,
  // [43] frame_damaged, [47:44] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int WS_W   = $clog2(MAX_WIDTH + 1);
  localparam int HS_W   = $clog2(MAX_HEIGHT + 1);
  localparam int BAND_X = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int BAND_Y = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int COL_W  = (BAND_X > 1) ? $clog2(BAND_X) : 1;
  localparam int ROW_W  = (BAND_Y > 1) ? $clog2(BAND_Y) : 1;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(OUTQ_DEPTH + 1);

  logic             cfg_we;
  logic             in_acc;
  logic             in_inval;
  logic [WS_W-1:0]  w_eff;
  logic [HS_W-1:0]  h_eff;
  logic [AW-1:0]    rd_addr;
  logic [COL_W-1:0] s0_col;
  logic [ROW_W-1:0] s0_row;
  step_ctl_t        s0_ctl;
  logic [PIX_W-1:0] ram_rdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic             res_push;
  tile_res_t        res;
  tile_res_t        q_data;
  logic [CNT_W-1:0] q_cnt;
  logic             busy;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_acc    = in_tvalid & in_tready;
  assign in_inval  = in_tuser == CMD_INVALIDATE;
  assign in_tready = ({1'b0, q_cnt} + {{CNT_W{1'b0}}, busy}) < (CNT_W + 1)'(OUTQ_DEPTH);

  tfdd_raster #(
    .TILE_SIZE (TILE_SIZE),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .step      (in_acc),
    .step_inval(in_inval),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .rd_addr   (rd_addr),
    .col       (s0_col),
    .row       (s0_row),
    .ctl       (s0_ctl)
  );

  tfdd_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (in_acc & !in_inval),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  tfdd_tile #(
    .TILE_SIZE (TILE_SIZE),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_tile (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_we),
    .s0_ctl   (s0_ctl),
    .s0_col   (s0_col),
    .s0_row   (s0_row),
    .s0_addr  (rd_addr),
    .s0_pix   (in_tdata),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .ram_rdata(ram_rdata),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .res_push (res_push),
    .res      (res),
    .busy     (busy)
  );

  tfdd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (q_data),
    .count    (q_cnt)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, q_data.frame_damaged, q_data.damaged,
                      q_data.span_y, q_data.span_x, q_data.top, q_data.left,
                      q_data.row, q_data.col};
  assign out_tlast = q_data.last;

endmodule

### design/tfdd_checker.sv
`timescale 1ns / 1ps

module tfdd_checker import tfdd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  a_no_beat_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  a_frame_flag_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_FDMG_BIT] |-> out_tlast)
    else $error("frame damage flag outside last tile");

  a_last_tile_damage: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tdata[OUT_DMG_BIT] |-> out_tdata[OUT_FDMG_BIT])
    else $error("damaged last tile without frame damage");

endmodule

bind tile_frame_damage_detector tfdd_checker u_tfdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

### verif/tb_tile_frame_damage_detector.sv
`timescale 1ns / 1ps

module tb_tile_frame_damage_detector;
  import tfdd_pkg::*;

  localparam int TILE         = TILE_SIZE_DEF;
  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int MAX_H        = MAX_HEIGHT_DEF;
  localparam int BANDS        = MAX_W / TILE;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SMALL_ITEMS  = 250;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX   = 10;

  class tile_damage_predictor;
    bit [PIX_W-1:0] prev_pix [MAX_W*MAX_H];
    bit             band_dirty [BANDS];
    bit [CFG_W-1:0] width_reg;
    bit [CFG_W-1:0] height_reg;
    int             pos_x;
    int             pos_y;
    bit             seen_frame;
    bit             frame_hit;
    tile_res_t      expected_tiles [$];
    int             tiles_checked;
    int             mismatches;
    int             invalidates;
    int             pixels;

    function new();
      width_reg  = CFG_W'(CFG_RESET);
      height_reg = CFG_W'(CFG_RESET);
      restart();
    endfunction

    function void restart();
      foreach (band_dirty[i]) band_dirty[i] = 1'b0;
      pos_x      = 0;
      pos_y      = 0;
      seen_frame = 1'b0;
      frame_hit  = 1'b0;
    endfunction

    function int eff_w();
      int v;
      v = width_reg;
      return (v < 1) ? 1 : (v > MAX_W) ? MAX_W : v;
    endfunction

    function int eff_h();
      int v;
      v = height_reg;
      return (v < 1) ? 1 : (v > MAX_H) ? MAX_H : v;
    endfunction

    function int next_index();
      if (pos_x >= eff_w() || pos_y >= eff_h()) return 0;
      return pos_y * MAX_W + pos_x;
    endfunction

    function bit [PIX_W-1:0] stored_next();
      return prev_pix[next_index()];
    endfunction

    function bit at_frame_start();
      return next_index() == 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [CFG_W-1:0] v);
      if (idx == REG_WIDTH) width_reg = v;
      else height_reg = v;
      restart();
    endfunction

    function void accept_beat(cmd_t c, bit [PIX_W-1:0] pix);
      int        w, h, x, y, col, row, idx, sx, sy;
      bit        differ, right_end, bottom_end, is_last, dmg;
      tile_res_t t;
      if (c == CMD_INVALIDATE) begin
        invalidates++;
        restart();
        return;
      end
      pixels++;
      w = eff_w();
      h = eff_h();
      if (pos_x >= w || pos_y >= h) begin
        pos_x = 0;
        pos_y = 0;
      end
      x   = pos_x;
      y   = pos_y;
      col = x / TILE;
      row = y / TILE;
      idx = y * MAX_W + x;
      differ        = prev_pix[idx] != pix;
      prev_pix[idx] = pix;
      if (differ) band_dirty[col] = 1'b1;
      right_end  = (x % TILE == TILE - 1) || (x == w - 1);
      bottom_end = (y % TILE == TILE - 1) || (y == h - 1);
      is_last    = (x == w - 1) && (y == h - 1);
      if (x + 1 < w) begin
        pos_x = x + 1;
      end else begin
        pos_x = 0;
        pos_y = (y + 1 < h) ? y + 1 : 0;
      end
      if (!(right_end && bottom_end)) return;
      dmg = !seen_frame || band_dirty[col];
      band_dirty[col] = 1'b0;
      if (dmg) frame_hit = 1'b1;
      sx = w - col * TILE;
      if (sx > TILE) sx = TILE;
      sy = h - row * TILE;
      if (sy > TILE) sy = TILE;
      t.col           = COL_OUT_W'(col);
      t.row           = COL_OUT_W'(row);
      t.left          = POS_OUT_W'(col * TILE);
      t.top           = POS_OUT_W'(row * TILE);
      t.span_x        = SPAN_OUT_W'(sx);
      t.span_y        = SPAN_OUT_W'(sy);
      t.damaged       = dmg;
      t.frame_damaged = is_last && frame_hit;
      t.last          = is_last;
      expected_tiles.push_back(t);
      if (is_last) begin
        seen_frame = 1'b1;
        frame_hit  = 1'b0;
        foreach (band_dirty[i]) band_dirty[i] = 1'b0;
      end
    endfunction

    function string tile_str(tile_res_t t);
      return $sformatf("col %0d row %0d left %0d top %0d span %0dx%0d dmg %0b fdmg %0b last %0b",
                       t.col, t.row, t.left, t.top, t.span_x, t.span_y,
                       t.damaged, t.frame_damaged, t.last);
    endfunction

    function void check_tile(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      tile_res_t got;
      tile_res_t want;
      got = {tlast, tdata[OUT_FDMG_BIT:0]};
      if (expected_tiles.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("tile beat with nothing pending: %s", tile_str(got));
        return;
      end
      want = expected_tiles.pop_front();
      tiles_checked++;
      if (got.col !== want.col || got.row !== want.row ||
          got.left !== want.left || got.top !== want.top ||
          got.span_x !== want.span_x || got.span_y !== want.span_y ||
          got.damaged !== want.damaged || got.frame_damaged !== want.frame_damaged ||
          got.last !== want.last || tdata[OUT_TDATA_W-1:OUT_FDMG_BIT+1] !== '0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("tile beat mismatch: expected %s, got %s pad %h",
                   tile_str(want), tile_str(got), tdata[OUT_TDATA_W-1:OUT_FDMG_BIT+1]);
      end
    endfunction

    function void flag_leftover();
      if (expected_tiles.size() != 0) begin
        $display("%0d tile beats never arrived, oldest: %s",
                 expected_tiles.size(), tile_str(expected_tiles[0]));
        mismatches += expected_tiles.size();
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata;
  logic [CMD_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  tile_damage_predictor pred;
  int                   cycles;
  int                   burst_left;
  int                   cfg_writes;

  tile_frame_damage_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pred.check_tile(out_tdata, out_tlast);
  end

  initial begin
    int mode;
    int len;
    int period;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          len = $urandom_range(20, 200);
          repeat (len) begin
            out_tready <= 1'b1;
            @(posedge clk);
          end
        end
        1: begin
          len = $urandom_range(20, 100);
          repeat (len) begin
            out_tready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        end
        2: begin
          len = $urandom_range(1, 30);
          repeat (len) begin
            out_tready <= 1'b0;
            @(posedge clk);
          end
          out_tready <= 1'b1;
          @(posedge clk);
        end
        default: begin
          period = $urandom_range(2, 5);
          len    = $urandom_range(4, 20) * period;
          for (int k = 0; k < len; k++) begin
            out_tready <= (k % period) == 0;
            @(posedge clk);
          end
        end
      endcase
    end
  end

  task automatic push_beat(cmd_t c, logic [PIX_W-1:0] pix);
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= pix;
    do @(posedge clk); while (in_tready !== 1'b1);
    pred.accept_beat(c, pix);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pred.expected_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pred.write_reg(idx, v);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic run_frames(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int frames,
                            bit with_inval);
    int             n_pix;
    int             inval_den;
    int             change_den;
    int             sent;
    logic [PIX_W-1:0] pix;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
    end else begin
      write_reg(REG_HEIGHT, h);
      write_reg(REG_WIDTH, w);
    end
    n_pix      = frames * pred.eff_w() * pred.eff_h();
    inval_den  = (with_inval && $urandom_range(0, 1)) ? 2 * n_pix : 0;
    change_den = 1;
    sent       = 0;
    while (sent < n_pix) begin
      if (inval_den > 0 && $urandom_range(0, inval_den - 1) == 0) begin
        push_beat(CMD_INVALIDATE, $urandom);
      end else begin
        if (pred.at_frame_start()) begin
          case ($urandom_range(0, 3))
            0:       change_den = 0;
            1:       change_den = 32;
            2:       change_den = 4;
            default: change_den = 1;
          endcase
        end
        if (change_den != 0 && $urandom_range(0, change_den - 1) == 0) pix = $urandom;
        else pix = pred.stored_next();
        push_beat(CMD_PIXEL, pix);
        sent++;
      end
      pace();
    end
  endtask

  initial begin
    int               base;
    int               w;
    int               h;
    int               hmax;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    pred       = new();
    burst_left = 0;
    cfg_writes = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_PIXEL;
    cfg_valid  = 1'b0;
    cfg_index  = REG_WIDTH;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_beat(CMD_PIXEL, 32'h0000_0000);
    pace();
    push_beat(CMD_PIXEL, 32'hFFFF_FFFF);
    pace();
    push_beat(CMD_INVALIDATE, 32'hA5A5_A5A5);
    pace();

    write_reg(REG_WIDTH, 11'd1);
    write_reg(REG_HEIGHT, 11'd1);
    push_beat(CMD_PIXEL, 32'h0000_0000);
    pace();
    push_beat(CMD_PIXEL, 32'h0000_0000);
    pace();
    push_beat(CMD_PIXEL, 32'hFFFF_FFFF);
    pace();
    push_beat(CMD_INVALIDATE, 32'h0000_0000);
    pace();
    push_beat(CMD_PIXEL, 32'hFFFF_FFFF);
    pace();
    push_beat(CMD_PIXEL, 32'hFFFF_FFFF);
    pace();

    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd2);
    push_beat(CMD_PIXEL, 32'h1234_5678);
    pace();
    push_beat(CMD_PIXEL, 32'h9ABC_DEF0);
    pace();
    push_beat(CMD_PIXEL, 32'h1234_5678);
    pace();
    push_beat(CMD_PIXEL, 32'h9ABC_DEF0);
    pace();
    push_beat(CMD_PIXEL, 32'h1234_5678);
    pace();
    push_beat(CMD_PIXEL, 32'h6543_210F);
    pace();

    run_frames(11'd2047, 11'd1, 1, 1'b0);
    run_frames(11'd1, 11'd320, 1, 1'b0);

    base = pred.pixels;
    while (pred.pixels < base + SMALL_ITEMS) begin
      w    = $urandom_range(1, 140);
      hmax = 400 / w;
      if (hmax > 140) hmax = 140;
      h  = $urandom_range(1, hmax);
      wv = ($urandom_range(0, 11) == 0) ? 11'd0 : CFG_W'(w);
      hv = ($urandom_range(0, 11) == 0) ? 11'd0 : CFG_W'(h);
      run_frames(wv, hv, $urandom_range(2, 4), 1'b1);
    end

    settle();
    pred.flag_leftover();
    $display("Ran %0d pixel beats and %0d invalidates over %0d register writes,",
             pred.pixels, pred.invalidates, cfg_writes);
    $display("checked %0d tile beats from 1x1 up to full-width and tall narrow frames",
             pred.tiles_checked);
    if (pred.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
